[rtl/div128_pkg.sv]
// shared constants, operation codes and the pipeline stage payload type
// for the 128-bit divider; no dependencies
package div128_pkg;

  localparam int OPERAND_BITS = 128;
  localparam int FULL_BITS    = 128;
  localparam int HALF_BITS    = 64;

  localparam logic [1:0] ACT_UDIV = 2'd0;
  localparam logic [1:0] ACT_SDIV = 2'd1;
  localparam logic [1:0] ACT_UREM = 2'd2;
  localparam logic [1:0] ACT_SREM = 2'd3;

  // payload carried down the division pipeline
  typedef struct packed {
    logic                    neg_q;   // negate quotient at the end
    logic                    neg_r;   // negate remainder at the end
    logic                    is_rem;  // deliver remainder instead of quotient
    logic                    zero;    // divisor was zero
    logic [OPERAND_BITS-1:0] rem;     // partial remainder
    logic [OPERAND_BITS-1:0] aq;      // dividend bits out on top, quotient bits in below
    logic [OPERAND_BITS-1:0] dvs;     // divisor magnitude
  } stage_t;

endpackage

[rtl/div128_if.sv]
// valid/ready channel interfaces for the divider operand and answer beats
// depends on div128_pkg
interface div128_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic [div128_pkg::HALF_BITS-1:0]  dividend_high;
  logic [div128_pkg::HALF_BITS-1:0]  dividend_low;
  logic [div128_pkg::HALF_BITS-1:0]  divisor_high;
  logic [div128_pkg::HALF_BITS-1:0]  divisor_low;

  modport source (output valid, action, dividend_high, dividend_low, divisor_high,
                  divisor_low, input ready);
  modport sink   (input valid, action, dividend_high, dividend_low, divisor_high,
                  divisor_low, output ready);
endinterface

interface div128_out_if;
  logic                              valid;
  logic                              ready;
  logic [div128_pkg::HALF_BITS-1:0]  answer_high;
  logic [div128_pkg::HALF_BITS-1:0]  answer_low;
  logic                              zero_divisor;

  modport source (output valid, answer_high, answer_low, zero_divisor, input ready);
  modport sink   (input valid, answer_high, answer_low, zero_divisor, output ready);
endinterface

[rtl/divider_128bit_signed_unsigned.sv]
// pipeline: an accepted operand beat passes one input stage, one register per
// division step and one output stage before it leaves as its answer beat
// throughput: one beat per cycle; the whole pipeline advances together and
// holds while the answer register is full and not taken
// reset: synchronous active-low rst_n clears all valid bits, payload is not reset
module divider_128bit_signed_unsigned (
  input  logic                clk,
  input  logic                rst_n,
  div128_in_if.sink           in_ch,
  div128_out_if.source        out_ch
);

  localparam int W = div128_pkg::OPERAND_BITS;
  localparam int F = div128_pkg::FULL_BITS;
  localparam int H = div128_pkg::HALF_BITS;

  // global advance: move everything when the answer slot is free or drains
  logic adv;

  // stage chain: index 0 is the input register, index W the last step
  logic               vld_w [0:W];
  div128_pkg::stage_t stg_w [0:W];

  // input stage
  logic               in_vld_r;
  div128_pkg::stage_t in_stg_r;
  div128_pkg::stage_t in_stg_nxt;
  logic [F-1:0]       a_full;
  logic [F-1:0]       b_full;
  logic [W-1:0]       a_trim;
  logic [W-1:0]       b_trim;
  logic               signed_op;
  logic               is_rem;
  logic               a_neg;
  logic               b_neg;

  // output stage
  logic               out_valid_r;
  logic [F-1:0]       answer_r;
  logic [F-1:0]       answer_nxt;
  logic               zero_r;
  logic [W-1:0]       mag;
  logic               neg;
  logic [W-1:0]       res;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // operand conditioning: trim to operand width, take magnitudes for signed ops
  always_comb begin
    a_full    = {in_ch.dividend_high, in_ch.dividend_low};
    b_full    = {in_ch.divisor_high, in_ch.divisor_low};
    a_trim    = a_full[W-1:0];
    b_trim    = b_full[W-1:0];
    signed_op = (in_ch.action == div128_pkg::ACT_SDIV) ||
                (in_ch.action == div128_pkg::ACT_SREM);
    is_rem    = (in_ch.action == div128_pkg::ACT_UREM) ||
                (in_ch.action == div128_pkg::ACT_SREM);
    a_neg     = signed_op && a_trim[W-1];
    b_neg     = signed_op && b_trim[W-1];

    in_stg_nxt.neg_q  = a_neg ^ b_neg;
    in_stg_nxt.neg_r  = a_neg;
    in_stg_nxt.is_rem = is_rem;
    in_stg_nxt.zero   = (b_trim == '0);
    in_stg_nxt.rem    = '0;
    in_stg_nxt.aq     = a_neg ? (W'(0) - a_trim) : a_trim;
    in_stg_nxt.dvs    = b_neg ? (W'(0) - b_trim) : b_trim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_stg_r <= in_stg_nxt;
    end
  end

  assign vld_w[0] = in_vld_r;
  assign stg_w[0] = in_stg_r;

  // one register stage per quotient bit, most significant first
  for (genvar k = 0; k < W; k++) begin : g_step
    div128_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (vld_w[k]),
      .stg_i (stg_w[k]),
      .vld_o (vld_w[k+1]),
      .stg_o (stg_w[k+1])
    );
  end

  // sign fixup: remainder follows the dividend, quotient negated on sign mismatch
  always_comb begin
    mag        = stg_w[W].is_rem ? stg_w[W].rem : stg_w[W].aq;
    neg        = stg_w[W].is_rem ? stg_w[W].neg_r : stg_w[W].neg_q;
    res        = neg ? (W'(0) - mag) : mag;
    answer_nxt = F'(res);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_w[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      answer_r <= answer_nxt;
      zero_r   <= stg_w[W].zero;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.answer_high  = answer_r[F-1:H];
  assign out_ch.answer_low   = answer_r[H-1:0];
  assign out_ch.zero_divisor = zero_r;

endmodule

[rtl/div128_step.sv]
// one restoring shift-and-subtract step with its pipeline register
// depends on div128_pkg
module div128_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               vld_i,
  input  div128_pkg::stage_t stg_i,
  output logic               vld_o,
  output div128_pkg::stage_t stg_o
);

  localparam int W = div128_pkg::OPERAND_BITS;

  logic                vld_r;
  div128_pkg::stage_t  stg_r;
  div128_pkg::stage_t  stg_nxt;
  logic [W-1:0]        shifted;
  logic [W:0]          diff;
  logic                ge;

  always_comb begin
    // remainder shifts left, taking the next dividend bit; width stays W
    shifted = {stg_i.rem[W-2:0], stg_i.aq[W-1]};
    diff    = {1'b0, shifted} - {1'b0, stg_i.dvs};
    ge      = !diff[W];
    stg_nxt     = stg_i;
    stg_nxt.rem = ge ? diff[W-1:0] : shifted;
    stg_nxt.aq  = {stg_i.aq[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r <= stg_nxt;
    end
  end

  assign vld_o = vld_r;
  assign stg_o = stg_r;

endmodule

[rtl/div128_chk.sv]
// port-level checks for the divider handshakes, bound to the top level
// depends on div128_pkg and divider_128bit_signed_unsigned
module div128_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [div128_pkg::HALF_BITS-1:0] answer_high,
  input logic [div128_pkg::HALF_BITS-1:0] answer_low,
  input logic                             zero_divisor
);

  // answer beat held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("answer beat dropped while stalled");

  // stalled answer payload does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(answer_high) && $stable(answer_low) &&
                                $stable(zero_divisor))
    else $error("answer payload changed while stalled");

  // input side opens whenever the answer slot is free or draining
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("operand ready does not follow answer slot");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("answer valid after reset");

endmodule

bind divider_128bit_signed_unsigned div128_chk u_div128_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .answer_high  (out_ch.answer_high),
  .answer_low   (out_ch.answer_low),
  .zero_divisor (out_ch.zero_divisor)
);

[tb/sv/tb_divider_128bit_signed_unsigned.sv]
`timescale 1ns / 100ps
// self-checking bench for the 128-bit signed/unsigned divider: random and
// directed operand beats, predicted answers compared beat by beat on the output
// depends on div128_pkg, div128_if and divider_128bit_signed_unsigned
module tb_divider_128bit_signed_unsigned;

  // expected answer beat, same fields as the output channel
  typedef struct packed {
    logic [div128_pkg::HALF_BITS-1:0] answer_high;
    logic [div128_pkg::HALF_BITS-1:0] answer_low;
    logic                             zero_divisor;
  } answer_t;

  localparam int FB           = div128_pkg::FULL_BITS;
  localparam int HB           = div128_pkg::HALF_BITS;
  localparam int OB           = div128_pkg::OPERAND_BITS;
  localparam int RAND_ITEMS   = 1150;
  localparam int MAX_IDLE     = 13;
  localparam int PIPE_LATENCY = 130;
  localparam int DRAIN_LIMIT  = 20000;

  logic clk;
  logic rst_n;

  div128_in_if  in_ch ();
  div128_out_if out_ch ();

  divider_128bit_signed_unsigned u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // answers still in flight, oldest first
  answer_t pending_answers [$];
  int      mismatch_count;

  // idling switches, flipped by the random test to get gap-free stretches
  bit src_idle_en;
  bit snk_idle_en;

  logic [1:0] all_actions [4] = '{div128_pkg::ACT_UDIV, div128_pkg::ACT_SDIV,
                                  div128_pkg::ACT_UREM, div128_pkg::ACT_SREM};

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // predicted divider answer: optional absolute values, then one restoring
  // shift-and-subtract step per operand bit, msb first, then sign fixups
  function automatic answer_t predict_answer(logic [1:0] act, logic [FB-1:0] dividend,
                                             logic [FB-1:0] divisor);
    logic [FB-1:0] width_mask;
    logic [FB-1:0] mag_a;
    logic [FB-1:0] mag_b;
    logic [FB-1:0] quo;
    logic [FB-1:0] part;
    logic          signed_op;
    logic          is_rem;
    logic          a_neg;
    logic          b_neg;
    answer_t       res;
    width_mask = (OB >= FB) ? '1 : ((FB'(1) << OB) - 1'b1);
    signed_op  = (act == div128_pkg::ACT_SDIV) || (act == div128_pkg::ACT_SREM);
    is_rem     = (act == div128_pkg::ACT_UREM) || (act == div128_pkg::ACT_SREM);
    mag_a      = dividend & width_mask;
    mag_b      = divisor & width_mask;
    a_neg      = 1'b0;
    b_neg      = 1'b0;
    quo        = '0;
    part       = '0;
    if (signed_op) begin
      a_neg = mag_a[OB-1];
      b_neg = mag_b[OB-1];
      if (a_neg) mag_a = (-mag_a) & width_mask;
      if (b_neg) mag_b = (-mag_b) & width_mask;
    end
    // partial remainder is kept at operand width, so the top bit may drop off
    for (int i = OB - 1; i >= 0; i--) begin
      part = ((part << 1) | FB'(mag_a[i])) & width_mask;
      if (part >= mag_b) begin
        part   = (part - mag_b) & width_mask;
        quo[i] = 1'b1;
      end
    end
    if (is_rem) begin
      if (signed_op && a_neg) part = (-part) & width_mask;
      quo = part;
    end else if (signed_op && (a_neg ^ b_neg)) begin
      quo = (-quo) & width_mask;
    end
    res.answer_high  = quo[FB-1:HB];
    res.answer_low   = quo[HB-1:0];
    res.zero_divisor = (mag_b == '0);
    return res;
  endfunction

  // random operand with a spread of magnitudes so quotients are not all 0 or 1
  function automatic logic [FB-1:0] make_operand();
    logic [FB-1:0] val;
    int            kind;
    int            bits;
    kind = $urandom_range(0, 11);
    val  = {$urandom, $urandom, $urandom, $urandom};
    case (kind)
      0: begin
        val = '0;
      end
      1: begin
        val = FB'($urandom_range(1, 16));
      end
      2: begin
        val = '1;
      end
      3: begin
        val = {1'b1, {(FB-1){1'b0}}};
      end
      4: begin
        // full-width random value
      end
      default: begin
        bits = $urandom_range(1, FB);
        if (bits < FB) val = val & ((FB'(1) << bits) - 1'b1);
        // negative values of every magnitude for the signed codes
        if ($urandom_range(0, 1) == 1) val = -val;
      end
    endcase
    return val;
  endfunction

  // send one operand beat; the expected answer is queued at acceptance
  task automatic send_operands(logic [1:0] act, logic [FB-1:0] dividend,
                               logic [FB-1:0] divisor);
    int gap;
    gap = src_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.dividend_high <= dividend[FB-1:HB];
    in_ch.dividend_low  <= dividend[HB-1:0];
    in_ch.divisor_high  <= divisor[FB-1:HB];
    in_ch.divisor_low   <= divisor[HB-1:0];
    do @(posedge clk); while (!in_ch.ready);
    pending_answers.insert(pending_answers.size(), predict_answer(act, dividend, divisor));
  endtask

  // largest and smallest operands under every code
  task automatic test_extremes();
    foreach (all_actions[k]) begin
      send_operands(all_actions[k], '1, FB'(1));
      send_operands(all_actions[k], '0, '1);
    end
  endtask

  // divide by zero: loop output, flag raised, signed fixups still applied
  task automatic test_zero_divisor();
    logic [FB-1:0] neg_val;
    neg_val = {1'b1, {(FB-2){1'b0}}, 1'b1};
    foreach (all_actions[k]) send_operands(all_actions[k], neg_val, '0);
    send_operands(div128_pkg::ACT_SDIV, FB'(12345), '0);
    send_operands(div128_pkg::ACT_SREM, FB'(12345), '0);
  endtask

  // most negative value over minus one wraps, remainder zero
  task automatic test_min_over_minus_one();
    logic [FB-1:0] min_val;
    min_val = {1'b1, {(FB-1){1'b0}}};
    send_operands(div128_pkg::ACT_SDIV, min_val, '1);
    send_operands(div128_pkg::ACT_SREM, min_val, '1);
    send_operands(div128_pkg::ACT_UDIV, min_val, '1);
  endtask

  // all four sign combinations for quotient and remainder
  task automatic test_sign_mix();
    send_operands(div128_pkg::ACT_SDIV, FB'(7), FB'(2));
    send_operands(div128_pkg::ACT_SDIV, -FB'(7), FB'(2));
    send_operands(div128_pkg::ACT_SDIV, FB'(7), -FB'(2));
    send_operands(div128_pkg::ACT_SDIV, -FB'(7), -FB'(2));
    send_operands(div128_pkg::ACT_SREM, FB'(7), FB'(2));
    send_operands(div128_pkg::ACT_SREM, -FB'(7), FB'(2));
    send_operands(div128_pkg::ACT_SREM, FB'(7), -FB'(2));
    send_operands(div128_pkg::ACT_SREM, -FB'(7), -FB'(2));
  endtask

  // random codes and operands; idling on each side switched per block of beats
  task automatic test_random();
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 128 == 0) begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        snk_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_operands(2'($urandom_range(0, 3)), make_operand(), make_operand());
    end
  endtask

  // answer side: random stall before each beat, then compare with the oldest
  initial begin
    answer_t got;
    answer_t want;
    int      stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = snk_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.answer_high  = out_ch.answer_high;
      got.answer_low   = out_ch.answer_low;
      got.zero_divisor = out_ch.zero_divisor;
      if (pending_answers.size() == 0) begin
        // beat with nothing in flight
        mismatch_count++;
        $display("%0t: unexpected answer beat %h_%h zero=%b", $time,
                 got.answer_high, got.answer_low, got.zero_divisor);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: answer mismatch expected %h_%h zero=%b actual %h_%h zero=%b", $time,
                   want.answer_high, want.answer_low, want.zero_divisor,
                   got.answer_high, got.answer_low, got.zero_divisor);
        end
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // reset, directed tests, random test, drain, verdict
  initial begin
    int waited;
    mismatch_count = 0;
    src_idle_en    = 1'b1;
    snk_idle_en    = 1'b1;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.action        <= div128_pkg::ACT_UDIV;
    in_ch.dividend_high <= '0;
    in_ch.dividend_low  <= '0;
    in_ch.divisor_high  <= '0;
    in_ch.divisor_low   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_zero_divisor();
    test_min_over_minus_one();
    test_sign_mix();
    test_random();
    // last beat was taken at this edge, so drop valid now
    in_ch.valid <= 1'b0;

    // wait for the pipeline to hand back every answer
    waited = 0;
    while (pending_answers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_answers.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d answers never arrived", $time, pending_answers.size());
    end
    // extra pipeline depth to catch stray beats
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
